@@ rtl/sclt_pkg.sv @@
// ============================================================================
// Shell command line tokenizer package
// Event codes, character constants and the per-byte event list used by the
// tokenizer datapath.
// ============================================================================
package sclt_pkg;

	// Event codes carried on event_kind
	localparam logic [3:0] EV_CHAR = 4'd0;
	localparam logic [3:0] EV_WEND = 4'd1;
	localparam logic [3:0] EV_PIPE = 4'd2;
	localparam logic [3:0] EV_AMP  = 4'd3;
	localparam logic [3:0] EV_SEMI = 4'd4;
	localparam logic [3:0] EV_LT   = 4'd5;
	localparam logic [3:0] EV_GT   = 4'd6;
	localparam logic [3:0] EV_GTGT = 4'd7;
	localparam logic [3:0] EV_EOF  = 4'd8;
	localparam logic [3:0] EV_ERR  = 4'd9;

	// Most events one byte can cause (e.g. ">x" closing the line: gt, char, wend, eof)
	localparam int          MAX_EV = 4;
	localparam logic [2:0]  EV_CNT_MAX = 3'(MAX_EV);

	// Character constants
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_PIPE   = 8'h7C;

	// Events produced by one byte, in emission order
	typedef struct packed {
		logic [MAX_EV-1:0][3:0] kind;
		logic [MAX_EV-1:0][7:0] chr;
		logic [2:0]             cnt;
	} ev_list_t;

	// Token separators
	function automatic logic is_blank(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	// Operator bytes that end a word
	function automatic logic is_oper(logic [7:0] c);
		return (c == CH_PIPE) || (c == CH_AMP) || (c == CH_GT) || (c == CH_LT) ||
			(c == CH_SEMI);
	endfunction

	// Append one event; char payload only for character events
	function automatic ev_list_t push(ev_list_t l, logic [3:0] kind, logic [7:0] ch);
		ev_list_t r;
		r = l;
		if (r.cnt < EV_CNT_MAX) begin
			r.kind[r.cnt[1:0]] = kind;
			r.chr[r.cnt[1:0]]  = (kind == EV_CHAR) ? ch : 8'd0;
			r.cnt              = r.cnt + 3'd1;
		end
		return r;
	endfunction

endpackage

@@ rtl/shell_command_line_tokenizer.sv @@
// ============================================================================
// Shell command line tokenizer
// Lexes a command line one byte per transaction and streams token events:
// word characters, word ends, operators, redirects, EOF and error.
// ============================================================================
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------
//  byte in  | byte_valid / byte_ready  | text_byte[7:0], line_end
//  event out| event_valid / event_ready| event_kind[3:0], char_value[7:0],
//           |                          | last_of_item
//
//  The lexer mode is updated in the cycle a byte is accepted; its 0 to 4
//  events go into a 4-entry event buffer. While event_ready is high, the
//  buffer drains one event per cycle and a byte causing at most one event
//  sustains one byte per cycle; others hold the input while it drains.
//  byte_ready is high when the buffer is empty or its last event leaves now.
//  arst_n clears the mode to idle and empties the buffer.
//  A stall on the event side holds the buffer and, through it, the input.

module shell_command_line_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	// byte channel
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] text_byte,
	input  logic       line_end,
	// event channel
	output logic       event_valid,
	input  logic       event_ready,
	output logic [3:0] event_kind,
	output logic [7:0] char_value,
	output logic       last_of_item
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_BSL,
		MODE_DQ,
		MODE_DQBSL,
		MODE_SQ,
		MODE_GT,
		MODE_SKIP
	} mode_t;

	mode_t                mode_q;
	sclt_pkg::ev_list_t   ev_q;
	logic [2:0]           rem_q;
	logic [1:0]           rd_q;

	mode_t                mode_nxt;
	sclt_pkg::ev_list_t   ev_nxt;
	logic                 byte_acc;
	logic                 event_acc;

	// Handshakes
	assign event_valid = (rem_q != 3'd0);
	assign event_acc   = event_valid && event_ready;
	assign byte_ready  = (rem_q == 3'd0) || ((rem_q == 3'd1) && event_ready);
	assign byte_acc    = byte_valid && byte_ready;

	// Output event from the buffer head
	assign event_kind   = ev_q.kind[rd_q];
	assign char_value   = ev_q.chr[rd_q];
	assign last_of_item = (rem_q == 3'd1);

	// Per-byte lexing: next mode and the events this byte causes
	always_comb begin
		logic do_idle;
		logic do_word;
		do_idle  = 1'b0;
		do_word  = 1'b0;
		mode_nxt = mode_q;
		ev_nxt   = '0;

		if (mode_q == MODE_SKIP) begin
			// discard bytes until the line end
			mode_nxt = line_end ? MODE_IDLE : MODE_SKIP;
		end else begin
			if (text_byte != sclt_pkg::CH_NUL) begin
				case (mode_q)
					MODE_IDLE: begin
						do_idle = 1'b1;
					end
					MODE_WORD: begin
						if (sclt_pkg::is_blank(text_byte) || sclt_pkg::is_oper(text_byte)) begin
							ev_nxt  = sclt_pkg::push(ev_nxt, sclt_pkg::EV_WEND, 8'd0);
							do_idle = 1'b1;
						end else begin
							do_word = 1'b1;
						end
					end
					MODE_BSL: begin
						ev_nxt   = sclt_pkg::push(ev_nxt, sclt_pkg::EV_CHAR, text_byte);
						mode_nxt = MODE_WORD;
					end
					MODE_DQ: begin
						if (text_byte == sclt_pkg::CH_DQUOTE) begin
							mode_nxt = MODE_WORD;
						end else if (text_byte == sclt_pkg::CH_BSLASH) begin
							mode_nxt = MODE_DQBSL;
						end else begin
							ev_nxt = sclt_pkg::push(ev_nxt, sclt_pkg::EV_CHAR, text_byte);
						end
					end
					MODE_DQBSL: begin
						// only \" and \\ collapse to one character
						if (text_byte != sclt_pkg::CH_DQUOTE &&
							text_byte != sclt_pkg::CH_BSLASH) begin
							ev_nxt = sclt_pkg::push(ev_nxt, sclt_pkg::EV_CHAR,
								sclt_pkg::CH_BSLASH);
						end
						ev_nxt   = sclt_pkg::push(ev_nxt, sclt_pkg::EV_CHAR, text_byte);
						mode_nxt = MODE_DQ;
					end
					MODE_SQ: begin
						if (text_byte == sclt_pkg::CH_SQUOTE) begin
							mode_nxt = MODE_WORD;
						end else begin
							ev_nxt = sclt_pkg::push(ev_nxt, sclt_pkg::EV_CHAR, text_byte);
						end
					end
					MODE_GT: begin
						if (text_byte == sclt_pkg::CH_GT) begin
							ev_nxt   = sclt_pkg::push(ev_nxt, sclt_pkg::EV_GTGT, 8'd0);
							mode_nxt = MODE_IDLE;
						end else begin
							ev_nxt  = sclt_pkg::push(ev_nxt, sclt_pkg::EV_GT, 8'd0);
							do_idle = 1'b1;
						end
					end
					default: begin
						mode_nxt = MODE_IDLE;
					end
				endcase

				// Byte seen between tokens
				if (do_idle) begin
					if (sclt_pkg::is_blank(text_byte)) begin
						mode_nxt = MODE_IDLE;
					end else if (text_byte == sclt_pkg::CH_PIPE) begin
						ev_nxt   = sclt_pkg::push(ev_nxt, sclt_pkg::EV_PIPE, 8'd0);
						mode_nxt = MODE_IDLE;
					end else if (text_byte == sclt_pkg::CH_AMP) begin
						ev_nxt   = sclt_pkg::push(ev_nxt, sclt_pkg::EV_AMP, 8'd0);
						mode_nxt = MODE_IDLE;
					end else if (text_byte == sclt_pkg::CH_SEMI) begin
						ev_nxt   = sclt_pkg::push(ev_nxt, sclt_pkg::EV_SEMI, 8'd0);
						mode_nxt = MODE_IDLE;
					end else if (text_byte == sclt_pkg::CH_LT) begin
						ev_nxt   = sclt_pkg::push(ev_nxt, sclt_pkg::EV_LT, 8'd0);
						mode_nxt = MODE_IDLE;
					end else if (text_byte == sclt_pkg::CH_GT) begin
						mode_nxt = MODE_GT;
					end else begin
						do_word = 1'b1;
					end
				end

				// Byte that starts or continues a word
				if (do_word) begin
					if (text_byte == sclt_pkg::CH_BSLASH) begin
						mode_nxt = MODE_BSL;
					end else if (text_byte == sclt_pkg::CH_DQUOTE) begin
						mode_nxt = MODE_DQ;
					end else if (text_byte == sclt_pkg::CH_SQUOTE) begin
						mode_nxt = MODE_SQ;
					end else begin
						ev_nxt   = sclt_pkg::push(ev_nxt, sclt_pkg::EV_CHAR, text_byte);
						mode_nxt = MODE_WORD;
					end
				end
			end

			// Close the line on line end or a zero byte
			if (line_end || text_byte == sclt_pkg::CH_NUL) begin
				case (mode_nxt)
					MODE_IDLE: begin
						ev_nxt = sclt_pkg::push(ev_nxt, sclt_pkg::EV_EOF, 8'd0);
					end
					MODE_WORD: begin
						ev_nxt = sclt_pkg::push(ev_nxt, sclt_pkg::EV_WEND, 8'd0);
						ev_nxt = sclt_pkg::push(ev_nxt, sclt_pkg::EV_EOF, 8'd0);
					end
					MODE_GT: begin
						ev_nxt = sclt_pkg::push(ev_nxt, sclt_pkg::EV_GT, 8'd0);
						ev_nxt = sclt_pkg::push(ev_nxt, sclt_pkg::EV_EOF, 8'd0);
					end
					default: begin
						// open quote or dangling backslash
						ev_nxt = sclt_pkg::push(ev_nxt, sclt_pkg::EV_ERR, 8'd0);
					end
				endcase
				mode_nxt = line_end ? MODE_IDLE : MODE_SKIP;
			end
		end
	end

	// Mode and event buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			ev_q   <= '0;
			rem_q  <= 3'd0;
			rd_q   <= 2'd0;
		end else begin
			if (byte_acc) begin
				mode_q <= mode_nxt;
				ev_q   <= ev_nxt;
				rem_q  <= ev_nxt.cnt;
				rd_q   <= 2'd0;
			end else if (event_acc) begin
				rem_q <= rem_q - 3'd1;
				rd_q  <= rd_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	// A line end always returns the lexer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready && line_end |=> mode_q == MODE_IDLE)
		else $error("mode not idle after line end");

	// Bytes skipped after a zero byte cause no events
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready && mode_q == MODE_SKIP |=> !event_valid)
		else $error("events produced while skipping");

	// EOF and error always close the byte's event group
	assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && (event_kind == sclt_pkg::EV_EOF || event_kind == sclt_pkg::EV_ERR)
		|-> last_of_item)
		else $error("eof or error not last of its group");

	// After the last event of a group, a new group starts at the buffer head
	assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_ready && last_of_item |=> !event_valid || rd_q == 2'd0)
		else $error("event buffer read pointer not rewound");

	// Read pointer plus pending events never exceed the buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rem_q} + {2'b00, rd_q}) <= {1'b0, sclt_pkg::EV_CNT_MAX})
		else $error("event buffer overrun");
`endif

endmodule
